>>> sv/mll_pkg.sv
// Shared types, codes and keyword tables for the micro language lexer.
// No dependencies; used by mll_core, mll_outq and micro_language_lexer.
`default_nettype none

package mll_pkg;

  localparam int unsigned LineBitsDef = 16;
  localparam int unsigned NumKw       = 6;
  localparam int unsigned OutqDepth   = 4;
  localparam int unsigned OutqAw      = $clog2(OutqDepth);

  typedef enum logic [2:0] {
    ModeIdle    = 3'd0,
    ModeWord    = 3'd1,
    ModeNum     = 3'd2,
    ModeSlash   = 3'd3,
    ModeComment = 3'd4,
    ModeRel     = 3'd5,
    ModeBangEq  = 3'd6,
    ModeColon   = 3'd7
  } scan_mode_e;

  typedef enum logic [4:0] {
    TkMain   = 5'd0,
    TkId     = 5'd1,
    TkInt    = 5'd2,
    TkRead   = 5'd3,
    TkWrite  = 5'd4,
    TkIf     = 5'd5,
    TkElse   = 5'd6,
    TkWhile  = 5'd7,
    TkPlus   = 5'd8,
    TkMinus  = 5'd9,
    TkMul    = 5'd10,
    TkDiv    = 5'd11,
    TkAssign = 5'd12,
    TkLParen = 5'd13,
    TkRParen = 5'd14,
    TkLBrace = 5'd15,
    TkRBrace = 5'd16,
    TkComma  = 5'd17,
    TkRel    = 5'd18,
    TkSemi   = 5'd19,
    TkEof    = 5'd20
  } tok_kind_e;

  typedef struct packed {
    logic [7:0] source_byte;
    logic       end_of_input;
  } mll_in_t;

  typedef struct packed {
    logic [4:0]  token_kind;
    logic        lex_error;
    logic [15:0] line_number;
    logic        last_of_run;
  } mll_out_t;

  typedef struct packed {
    scan_mode_e        mode;
    logic [NumKw-1:0]  cands;
    logic [2:0]        wlen;
  } mll_state_t;

  // Results of one request: up to two, in order.
  typedef struct packed {
    logic [1:0] cnt;
    mll_out_t   res0;
    mll_out_t   res1;
  } mll_push_t;

  localparam logic [2:0] KwLen [NumKw] = '{3'd4, 3'd4, 3'd5, 3'd2, 3'd5, 3'd4};
  localparam tok_kind_e  KwCode [NumKw] = '{TkMain, TkRead, TkWrite, TkIf, TkWhile, TkElse};
  localparam logic [7:0] KwText [NumKw][5] = '{
    '{"m", "a", "i", "n", 8'h00},
    '{"r", "e", "a", "d", 8'h00},
    '{"w", "r", "i", "t", "e"},
    '{"i", "f", 8'h00, 8'h00, 8'h00},
    '{"w", "h", "i", "l", "e"},
    '{"e", "l", "s", "e", 8'h00}
  };

  // Character of keyword k at position pos, zero past the text.
  function automatic logic [7:0] kw_char(input int unsigned k, input logic [2:0] pos);
    logic [7:0] ch;
    case (pos)
      3'd0:    ch = KwText[k][0];
      3'd1:    ch = KwText[k][1];
      3'd2:    ch = KwText[k][2];
      3'd3:    ch = KwText[k][3];
      3'd4:    ch = KwText[k][4];
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

endpackage

`default_nettype wire

>>> sv/mll_core.sv
// Single-pass scan step: next scanner state and up to two results for one request.
// Depends on mll_pkg.
`default_nettype none

module mll_core #(
  parameter int unsigned LineBits = mll_pkg::LineBitsDef
) (
  input  mll_pkg::mll_state_t  state_i,
  input  logic [LineBits-1:0]  line_i,
  input  mll_pkg::mll_in_t     req_i,
  output mll_pkg::mll_state_t  state_o,
  output logic [LineBits-1:0]  line_o,
  output mll_pkg::mll_push_t   push_o
);

  localparam logic [LineBits-1:0] LineMax = '1;
  localparam logic [7:0] CharLf = 8'h0A;

  logic [7:0]                 c;
  logic                       is_alpha, is_digit, is_space;
  logic [mll_pkg::NumKw-1:0]  keep_cont, keep_new;
  logic [2:0]                 wlen_inc;
  mll_pkg::tok_kind_e         word_kind;
  logic [LineBits-1:0]        line_inc;
  logic [31:0]                line_ext;
  logic [15:0]                line16;
  logic                       rescan;
  logic                       a_v, a_e, b_v, b_e;
  mll_pkg::tok_kind_e         a_k, b_k;

  assign c        = req_i.source_byte;
  assign is_alpha = (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
  assign is_digit = (c >= "0" && c <= "9");
  assign is_space = (c == " ") || (c >= 8'd9 && c <= 8'd13);
  assign wlen_inc = (state_i.wlen == 3'd7) ? 3'd7 : state_i.wlen + 3'd1;
  assign line_inc = (line_i == LineMax) ? line_i : line_i + LineBits'(1);
  assign line_ext = 32'(line_i);
  assign line16   = (line_ext > 32'd65535) ? 16'hFFFF : line_ext[15:0];

  always_comb begin
    for (int unsigned k = 0; k < mll_pkg::NumKw; k++) begin
      keep_cont[k] = state_i.cands[k] && (state_i.wlen < mll_pkg::KwLen[k]) &&
                     (mll_pkg::kw_char(k, state_i.wlen) == c);
      keep_new[k]  = mll_pkg::kw_char(k, 3'd0) == c;
    end
  end

  // Lowest keyword index wins; lengths settle it anyway.
  always_comb begin
    word_kind = mll_pkg::TkId;
    for (int k = mll_pkg::NumKw - 1; k >= 0; k--) begin
      if (state_i.cands[k] && state_i.wlen == mll_pkg::KwLen[k]) begin
        word_kind = mll_pkg::KwCode[k];
      end
    end
  end

  // a: token closed by the pending state; b: token from the byte itself or eof
  always_comb begin
    state_o = state_i;
    line_o  = line_i;
    rescan  = 1'b0;
    a_v = 1'b0; a_k = mll_pkg::TkMain; a_e = 1'b0;
    b_v = 1'b0; b_k = mll_pkg::TkMain; b_e = 1'b0;
    if (req_i.end_of_input) begin
      unique case (state_i.mode) inside
        mll_pkg::ModeWord:  begin a_v = 1'b1; a_k = word_kind; end
        mll_pkg::ModeNum:   begin a_v = 1'b1; a_k = mll_pkg::TkInt; end
        mll_pkg::ModeSlash: begin a_v = 1'b1; a_k = mll_pkg::TkDiv; end
        mll_pkg::ModeRel:   begin a_v = 1'b1; a_k = mll_pkg::TkRel; end
        mll_pkg::ModeBangEq,
        mll_pkg::ModeColon: begin a_v = 1'b1; a_e = 1'b1; end
        default: ;
      endcase
      b_v           = 1'b1;
      b_k           = mll_pkg::TkEof;
      state_o.mode  = mll_pkg::ModeIdle;
      state_o.cands = '1;
      state_o.wlen  = 3'd0;
      line_o        = LineBits'(1);
    end else begin
      unique case (state_i.mode)
        mll_pkg::ModeIdle: rescan = 1'b1;
        mll_pkg::ModeWord: begin
          if (is_alpha || is_digit || c == "_") begin
            state_o.cands = keep_cont;
            state_o.wlen  = wlen_inc;
          end else begin
            a_v = 1'b1; a_k = word_kind; rescan = 1'b1;
          end
        end
        mll_pkg::ModeNum: begin
          if (!is_digit) begin
            a_v = 1'b1; a_k = mll_pkg::TkInt; rescan = 1'b1;
          end
        end
        mll_pkg::ModeSlash: begin
          if (c == "/") begin
            state_o.mode = mll_pkg::ModeComment;
          end else begin
            a_v = 1'b1; a_k = mll_pkg::TkDiv; rescan = 1'b1;
          end
        end
        mll_pkg::ModeComment: begin
          if (c == CharLf) begin
            line_o       = line_inc;
            state_o.mode = mll_pkg::ModeIdle;
          end
        end
        mll_pkg::ModeRel: begin
          a_v = 1'b1; a_k = mll_pkg::TkRel;
          if (c == "=") state_o.mode = mll_pkg::ModeIdle;
          else          rescan = 1'b1;
        end
        mll_pkg::ModeBangEq: begin
          a_v = 1'b1;
          if (c == "=") begin
            a_k = mll_pkg::TkRel; state_o.mode = mll_pkg::ModeIdle;
          end else begin
            a_e = 1'b1; rescan = 1'b1;
          end
        end
        mll_pkg::ModeColon: begin
          a_v = 1'b1;
          if (c == "=") begin
            a_k = mll_pkg::TkAssign; state_o.mode = mll_pkg::ModeIdle;
          end else begin
            a_e = 1'b1; rescan = 1'b1;
          end
        end
        default: ;
      endcase

      if (rescan) begin
        state_o.mode = mll_pkg::ModeIdle;
        if (is_space) begin
          if (c == CharLf) line_o = line_inc;
        end else if (is_alpha) begin
          state_o.mode  = mll_pkg::ModeWord;
          state_o.cands = keep_new;
          state_o.wlen  = 3'd1;
        end else if (is_digit) begin
          state_o.mode = mll_pkg::ModeNum;
        end else begin
          case (c) inside
            "(":      begin b_v = 1'b1; b_k = mll_pkg::TkLParen; end
            ")":      begin b_v = 1'b1; b_k = mll_pkg::TkRParen; end
            "{":      begin b_v = 1'b1; b_k = mll_pkg::TkLBrace; end
            "}":      begin b_v = 1'b1; b_k = mll_pkg::TkRBrace; end
            ",":      begin b_v = 1'b1; b_k = mll_pkg::TkComma; end
            ";":      begin b_v = 1'b1; b_k = mll_pkg::TkSemi; end
            "+":      begin b_v = 1'b1; b_k = mll_pkg::TkPlus; end
            "-":      begin b_v = 1'b1; b_k = mll_pkg::TkMinus; end
            "*":      begin b_v = 1'b1; b_k = mll_pkg::TkMul; end
            "/":      state_o.mode = mll_pkg::ModeSlash;
            "<", ">": state_o.mode = mll_pkg::ModeRel;
            "!", "=": state_o.mode = mll_pkg::ModeBangEq;
            ":":      state_o.mode = mll_pkg::ModeColon;
            default:  begin b_v = 1'b1; b_e = 1'b1; end
          endcase
        end
      end
    end
  end

  always_comb begin
    push_o.cnt = 2'(a_v) + 2'(b_v);
    push_o.res0.token_kind  = a_v ? a_k : b_k;
    push_o.res0.lex_error   = a_v ? a_e : b_e;
    push_o.res0.line_number = line16;
    push_o.res0.last_of_run = !(a_v && b_v);
    push_o.res1.token_kind  = b_k;
    push_o.res1.lex_error   = b_e;
    push_o.res1.line_number = line16;
    push_o.res1.last_of_run = 1'b1;
  end

endmodule

`default_nettype wire

>>> sv/mll_outq.sv
// Result queue: takes up to two results a cycle, hands out one.
// Depends on mll_pkg.
`default_nettype none

module mll_outq (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  mll_pkg::mll_push_t  push_i,
  input  logic                pop_i,
  output mll_pkg::mll_out_t   head_o,
  output logic                valid_o,
  output logic                room2_o,
  output logic [mll_pkg::OutqAw:0] cnt_o
);

  localparam int unsigned Aw = mll_pkg::OutqAw;

  mll_pkg::mll_out_t   mem_q [mll_pkg::OutqDepth];
  logic [Aw-1:0]       wr_q, rd_q, wr_d, rd_d, wr_p1;
  logic [Aw:0]         cnt_q, cnt_d;

  assign wr_p1   = wr_q + Aw'(1);
  assign wr_d    = wr_q + Aw'(push_i.cnt);
  assign rd_d    = rd_q + Aw'(pop_i);
  assign cnt_d   = cnt_q + (Aw+1)'(push_i.cnt) - (Aw+1)'(pop_i);
  assign head_o  = mem_q[rd_q];
  assign valid_o = cnt_q != '0;
  assign room2_o = cnt_q <= (Aw+1)'(mll_pkg::OutqDepth - 2);
  assign cnt_o   = cnt_q;

  always_ff @(posedge clk_i) begin
    if (push_i.cnt != 2'd0) mem_q[wr_q] <= push_i.res0;
    if (push_i.cnt == 2'd2) mem_q[wr_p1] <= push_i.res1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

endmodule

`default_nettype wire

>>> sv/micro_language_lexer.sv
// Micro language lexer: one source byte per request, tokens out.
// Path: each request waits in the input register, then its results wait in the result queue.
// Throughput: one request per cycle while the queue has room; result pairs leave singly.
// The four-entry result queue sets how far requests can run ahead of the output.
// Reset: scanner idle, line one, queue empty. Depends on mll_pkg, mll_core, mll_outq.
`default_nettype none

module micro_language_lexer #(
  parameter int unsigned LineBits = mll_pkg::LineBitsDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  mll_pkg::mll_in_t   in_data_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output mll_pkg::mll_out_t  out_data_o
);

  mll_pkg::mll_in_t    in_q;
  logic                in_v_q, in_v_d;
  mll_pkg::mll_state_t state_q, state_d;
  logic [LineBits-1:0] line_q, line_d;
  mll_pkg::mll_push_t  core_push, push;
  logic                room2, take, accept, pop;
  logic [mll_pkg::OutqAw:0] q_cnt;

  assign take       = in_v_q && room2;
  assign in_stall_o = in_v_q && !take;
  assign accept     = in_valid_i && !in_stall_o;
  assign pop        = out_valid_o && !out_stall_i;
  assign in_v_d     = accept | (in_v_q & ~take);

  always_comb begin
    push     = core_push;
    push.cnt = take ? core_push.cnt : 2'd0;
  end

  mll_core #(.LineBits(LineBits)) u_core (
    .state_i (state_q),
    .line_i  (line_q),
    .req_i   (in_q),
    .state_o (state_d),
    .line_o  (line_d),
    .push_o  (core_push)
  );

  mll_outq u_outq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .pop_i   (pop),
    .head_o  (out_data_o),
    .valid_o (out_valid_o),
    .room2_o (room2),
    .cnt_o   (q_cnt)
  );

  always_ff @(posedge clk_i) begin
    if (accept) in_q <= in_data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_v_q        <= 1'b0;
      state_q.mode  <= mll_pkg::ModeIdle;
      state_q.cands <= '1;
      state_q.wlen  <= 3'd0;
      line_q        <= LineBits'(1);
    end else begin
      in_v_q <= in_v_d;
      if (take) begin
        state_q <= state_d;
        line_q  <= line_d;
      end
    end
  end

  a_q_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_cnt <= (mll_pkg::OutqAw+1)'(mll_pkg::OutqDepth))
    else $error("result queue overfilled");

  a_eof_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    take && in_q.end_of_input |=> state_q.mode == mll_pkg::ModeIdle &&
                                  line_q == LineBits'(1))
    else $error("scanner not restarted after end of input");

  a_eof_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    take && in_q.end_of_input |-> push.cnt != 2'd0)
    else $error("end of input gave no result");

  a_pair_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push.cnt == 2'd2 |-> !push.res0.last_of_run && push.res1.last_of_run)
    else $error("last-of-run flag wrong on a result pair");

endmodule

`default_nettype wire
